// ===== rtl/fm_chip_timer_register_block_top_macros.svh =====
// Assertion helpers for the timer register block.
`ifndef FM_CHIP_TIMER_REGISTER_BLOCK_TOP_MACROS_SVH
`define FM_CHIP_TIMER_REGISTER_BLOCK_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define FMT_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("implication check failed");
// Condition a implies condition b in the next cycle.
`define FMT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");
`else
`define FMT_ASSERT_IMPLIES(label, clk, rst, a, b)
`define FMT_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// ===== rtl/fmtmr_pkg.sv =====
package fmtmr_pkg;

   // Request codes on req_type
   localparam logic [1:0] REQ_ADDR = 2'd0;
   localparam logic [1:0] REQ_DATA = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // Register addresses decoded on data writes
   localparam logic [7:0] ADDR_TIMER_A_HIGH = 8'h24;
   localparam logic [7:0] ADDR_TIMER_A_LOW  = 8'h25;
   localparam logic [7:0] ADDR_TIMER_B      = 8'h26;
   localparam logic [7:0] ADDR_CONTROL      = 8'h27;
   localparam logic [7:0] ADDR_PRE_SLOW     = 8'h2D;
   localparam logic [7:0] ADDR_PRE_MID      = 8'h2E;
   localparam logic [7:0] ADDR_PRE_FAST     = 8'h2F;

   // Prescaler divisors
   localparam logic [2:0] FM_DIV_SLOW  = 3'd6;
   localparam logic [2:0] FM_DIV_MID   = 3'd3;
   localparam logic [2:0] FM_DIV_FAST  = 3'd2;
   localparam logic [2:0] SSG_DIV_SLOW = 3'd4;
   localparam logic [2:0] SSG_DIV_MID  = 3'd2;
   localparam logic [2:0] SSG_DIV_FAST = 3'd1;

   localparam logic [1:0] MODE_CSM = 2'b10;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TA_HIGH,
      OP_TA_LOW,
      OP_TB,
      OP_CONTROL,
      OP_PRE_SLOW,
      OP_PRE_MID,
      OP_PRE_FAST,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/fm_chip_timer_register_block_top.sv =====
// Timer A/B and mode register block of an FM sound chip.
// Request channel (req_valid/req_ready): each beat is an address write,
// a data write decoded against the latched address, or one sample tick.
// Result channel (rsp_valid/rsp_ready): exactly one beat per request, in
// order, showing status flags, prescaler divisors and 3CH/CSM mode after
// that request.
// The front stage latches the address and classifies each beat into an
// operation; a short queue (QUEUE_DEPTH entries) hands it to the back
// stage, which updates the timers and registers and holds the result.
// A request is held in a queue entry and then in the back-stage result
// register, which raises rsp_valid. Throughput: one request per cycle
// while rsp_ready is high, set by the single back-stage update.
// When the receiver stalls, the back stage holds its result and state;
// the queue absorbs further requests until full, then req_ready drops.
// Reset (synchronous, active high) clears timers, flags, mode and address
// latch, sets the divisors to 6 and 4, and empties the queue.
module fm_chip_timer_register_block_top
   import fmtmr_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_bus_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status_flags,
   output logic [2:0] rsp_fm_prescaler,
   output logic [2:0] rsp_ssg_prescaler,
   output logic       rsp_three_channel_mode,
   output logic       rsp_csm_mode
);

   // front to queue
   logic         push;
   cmd_type      push_cmd;
   // queue to back
   logic         pop;
   cmd_type      pop_cmd;
   q_status_type q_status;

   // latch address, classify each beat
   fmtmr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_bus_byte (req_bus_byte),
      .q_status_i   (q_status),
      .push_o       (push),
      .push_cmd_o   (push_cmd)
   );

   // decouple the front from a stalled back stage
   fmtmr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .push_cmd_i (push_cmd),
      .pop_i      (pop),
      .pop_cmd_o  (pop_cmd),
      .status_o   (q_status)
   );

   // execute operations, hold the result beat
   fmtmr_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_status_i             (q_status),
      .cmd_i                  (pop_cmd),
      .pop_o                  (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_status_flags       (rsp_status_flags),
      .rsp_fm_prescaler       (rsp_fm_prescaler),
      .rsp_ssg_prescaler      (rsp_ssg_prescaler),
      .rsp_three_channel_mode (rsp_three_channel_mode),
      .rsp_csm_mode           (rsp_csm_mode)
   );

endmodule

// ===== rtl/fmtmr_front.sv =====
module fmtmr_front
   import fmtmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_type,
   input  logic [7:0]   req_bus_byte,
   input  q_status_type q_status_i,
   output logic         push_o,
   output cmd_type      push_cmd_o
);

   logic [7:0] address_latch_ff;
   logic [7:0] address_latch_in;
   logic       accept;
   op_type     data_op;

   assign req_ready = !q_status_i.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      address_latch_in = address_latch_ff;
      if (accept && (req_type == REQ_ADDR)) begin
         address_latch_in = req_bus_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_latch_ff <= '0;
      end else begin
         address_latch_ff <= address_latch_in;
      end
   end

   // decode a data write against the latched address
   always_comb begin
      case (address_latch_ff)
         ADDR_TIMER_A_HIGH: data_op = OP_TA_HIGH;
         ADDR_TIMER_A_LOW:  data_op = OP_TA_LOW;
         ADDR_TIMER_B:      data_op = OP_TB;
         ADDR_CONTROL:      data_op = OP_CONTROL;
         ADDR_PRE_SLOW:     data_op = OP_PRE_SLOW;
         ADDR_PRE_MID:      data_op = OP_PRE_MID;
         ADDR_PRE_FAST:     data_op = OP_PRE_FAST;
         default:           data_op = OP_NONE;
      endcase
   end

   always_comb begin
      push_cmd_o.data = req_bus_byte;
      case (req_type)
         REQ_DATA: push_cmd_o.op = data_op;
         REQ_TICK: push_cmd_o.op = OP_TICK;
         default:  push_cmd_o.op = OP_NONE;
      endcase
   end

   assign push_o = accept;

endmodule

// ===== rtl/fmtmr_queue.sv =====
`include "fm_chip_timer_register_block_top_macros.svh"

module fmtmr_queue
   import fmtmr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_i,
   input  cmd_type      push_cmd_i,
   input  logic         pop_i,
   output cmd_type      pop_cmd_o,
   output q_status_type status_o
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign status_o.full  = (count_ff == CNT_W'(DEPTH));
   assign status_o.empty = (count_ff == '0);
   assign pop_cmd_o      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_i ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push_i && pop_i) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         entries_ff[wr_ptr_ff] <= push_cmd_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `FMT_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `FMT_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop_i, !status_o.empty)
   `FMT_ASSERT_IMPLIES(a_no_push_full, clock, reset, push_i, !status_o.full)

endmodule

// ===== rtl/fmtmr_back.sv =====
`include "fm_chip_timer_register_block_top_macros.svh"

module fmtmr_back
   import fmtmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status_i,
   input  cmd_type      cmd_i,
   output logic         pop_o,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [1:0]   rsp_status_flags,
   output logic [2:0]   rsp_fm_prescaler,
   output logic [2:0]   rsp_ssg_prescaler,
   output logic         rsp_three_channel_mode,
   output logic         rsp_csm_mode
);

   logic        rsp_valid_ff,  rsp_valid_in;
   logic [9:0]  ta_value_ff,   ta_value_in;
   logic [7:0]  tb_value_ff,   tb_value_in;
   logic        ta_run_ff,     ta_run_in;
   logic        tb_run_ff,     tb_run_in;
   logic        ta_en_ff,      ta_en_in;
   logic        tb_en_ff,      tb_en_in;
   logic [10:0] ta_count_ff,   ta_count_in;
   logic [12:0] tb_count_ff,   tb_count_in;
   logic [1:0]  overflow_ff,   overflow_in;
   logic [2:0]  fm_div_ff,     fm_div_in;
   logic [2:0]  ssg_div_ff,    ssg_div_in;
   logic [1:0]  mode_ff,       mode_in;

   logic [10:0] ta_load;
   logic [12:0] tb_load;
   logic [8:0]  tb_span;
   logic [10:0] ta_dec;
   logic [12:0] tb_dec;

   // state only moves when the result slot is free, so the slot holds the state
   assign pop_o = !q_status_i.empty && (!rsp_valid_ff || rsp_ready);

   assign ta_load = 11'd1024 - {1'b0, ta_value_ff};
   assign tb_span = 9'd256 - {1'b0, tb_value_ff};
   assign tb_load = {tb_span, 4'b0000};
   assign ta_dec  = ta_count_ff - 11'd1;
   assign tb_dec  = tb_count_ff - 13'd1;

   always_comb begin
      ta_value_in = ta_value_ff;
      tb_value_in = tb_value_ff;
      ta_run_in   = ta_run_ff;
      tb_run_in   = tb_run_ff;
      ta_en_in    = ta_en_ff;
      tb_en_in    = tb_en_ff;
      ta_count_in = ta_count_ff;
      tb_count_in = tb_count_ff;
      overflow_in = overflow_ff;
      fm_div_in   = fm_div_ff;
      ssg_div_in  = ssg_div_ff;
      mode_in     = mode_ff;
      if (pop_o) begin
         case (cmd_i.op)
            OP_TA_HIGH: ta_value_in = {cmd_i.data, ta_value_ff[1:0]};
            OP_TA_LOW:  ta_value_in = {ta_value_ff[9:2], cmd_i.data[1:0]};
            OP_TB:      tb_value_in = cmd_i.data;
            OP_CONTROL: begin
               if (cmd_i.data[0] != ta_run_ff) begin
                  ta_run_in = cmd_i.data[0];
                  if (cmd_i.data[0]) begin
                     ta_count_in = ta_load;
                  end
               end
               if (cmd_i.data[1] != tb_run_ff) begin
                  tb_run_in = cmd_i.data[1];
                  if (cmd_i.data[1]) begin
                     tb_count_in = tb_load;
                  end
               end
               ta_en_in = cmd_i.data[2];
               tb_en_in = cmd_i.data[3];
               if (cmd_i.data[4]) begin
                  overflow_in[0] = 1'b0;
               end
               if (cmd_i.data[5]) begin
                  overflow_in[1] = 1'b0;
               end
               mode_in = cmd_i.data[7:6];
            end
            OP_PRE_SLOW: begin
               fm_div_in  = FM_DIV_SLOW;
               ssg_div_in = SSG_DIV_SLOW;
            end
            OP_PRE_MID: begin
               if (fm_div_ff == FM_DIV_SLOW) begin
                  fm_div_in  = FM_DIV_MID;
                  ssg_div_in = SSG_DIV_MID;
               end
            end
            OP_PRE_FAST: begin
               fm_div_in  = FM_DIV_FAST;
               ssg_div_in = SSG_DIV_FAST;
            end
            OP_TICK: begin
               if (ta_run_ff) begin
                  if (ta_dec == '0) begin
                     ta_count_in = ta_load;
                     if (ta_en_ff) begin
                        overflow_in[0] = 1'b1;
                     end
                  end else begin
                     ta_count_in = ta_dec;
                  end
               end
               if (tb_run_ff) begin
                  if (tb_dec == '0) begin
                     tb_count_in = tb_load;
                     if (tb_en_ff) begin
                        overflow_in[1] = 1'b1;
                     end
                  end else begin
                     tb_count_in = tb_dec;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop_o) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         ta_value_ff  <= '0;
         tb_value_ff  <= '0;
         ta_run_ff    <= 1'b0;
         tb_run_ff    <= 1'b0;
         ta_en_ff     <= 1'b0;
         tb_en_ff     <= 1'b0;
         ta_count_ff  <= '0;
         tb_count_ff  <= '0;
         overflow_ff  <= '0;
         fm_div_ff    <= FM_DIV_SLOW;
         ssg_div_ff   <= SSG_DIV_SLOW;
         mode_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         ta_value_ff  <= ta_value_in;
         tb_value_ff  <= tb_value_in;
         ta_run_ff    <= ta_run_in;
         tb_run_ff    <= tb_run_in;
         ta_en_ff     <= ta_en_in;
         tb_en_ff     <= tb_en_in;
         ta_count_ff  <= ta_count_in;
         tb_count_ff  <= tb_count_in;
         overflow_ff  <= overflow_in;
         fm_div_ff    <= fm_div_in;
         ssg_div_ff   <= ssg_div_in;
         mode_ff      <= mode_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status_flags       = overflow_ff;
   assign rsp_fm_prescaler       = fm_div_ff;
   assign rsp_ssg_prescaler      = ssg_div_ff;
   assign rsp_three_channel_mode = (mode_ff != 2'b00);
   assign rsp_csm_mode           = (mode_ff == MODE_CSM);

   `FMT_ASSERT_IMPLIES(a_ta_count_live, clock, reset, ta_run_ff, ta_count_ff != '0)
   `FMT_ASSERT_IMPLIES(a_tb_count_live, clock, reset, tb_run_ff, tb_count_ff != '0)
   `FMT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid_ff && !rsp_ready, $stable(overflow_ff) && $stable(ta_count_ff) && rsp_valid_ff)
   `FMT_ASSERT_IMPLIES(a_fm_div_legal, clock, reset, 1'b1, (fm_div_ff == FM_DIV_SLOW) || (fm_div_ff == FM_DIV_MID) || (fm_div_ff == FM_DIV_FAST))

endmodule
